@@ hdl/b64sd_pkg.sv @@
package b64sd_pkg;

    localparam int QPTR_W = 2;
    localparam int QDEPTH = 1 << QPTR_W;
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    localparam logic [7:0] LOWER_OFFSET = 8'd71;
    localparam logic [7:0] DIGIT_OFFSET = 8'd4;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    localparam logic [1:0] WORD_IDX_FIRST = 2'd0;
    localparam logic [1:0] WORD_IDX_SECOND = 2'd1;
    localparam logic [1:0] WORD_IDX_THIRD = 2'd2;

    typedef struct packed {
        logic       stop;
        logic [5:0] val;
    } sextet_t;

    // One queue entry holds the words caused by one character.
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      last_idx;
        logic            has_data;
        logic            last;
    } group_t;

    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t    s;
        logic [7:0] diff;
        s    = '{stop: 1'b1, val: 6'd0};
        diff = 8'd0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            diff = ch - CHAR_UPPER_A;
            s    = '{stop: 1'b0, val: diff[5:0]};
        end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            diff = ch - LOWER_OFFSET;
            s    = '{stop: 1'b0, val: diff[5:0]};
        end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
            diff = ch + DIGIT_OFFSET;
            s    = '{stop: 1'b0, val: diff[5:0]};
        end else if (ch == CHAR_PLUS) begin
            s = '{stop: 1'b0, val: SEXTET_PLUS};
        end else if (ch == CHAR_SLASH) begin
            s = '{stop: 1'b0, val: SEXTET_SLASH};
        end
        return s;
    endfunction

    function automatic logic [7:0] byte_hi(input logic [5:0] s0, input logic [5:0] s1);
        return {s0, s1[5:4]};
    endfunction

    function automatic logic [7:0] byte_mid(input logic [5:0] s0, input logic [5:0] s1);
        return {s0[3:0], s1[5:2]};
    endfunction

    function automatic logic [7:0] byte_lo(input logic [5:0] s0, input logic [5:0] s1);
        return {s0[1:0], s1};
    endfunction

endpackage

@@ hdl/b64sd_char_if.sv @@
interface b64sd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink (input valid, input in_char, input in_last, output ready);
endinterface

@@ hdl/b64sd_byte_if.sv @@
interface b64sd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic       out_last;

    modport source (output valid, output out_byte, output out_byte_valid, output out_last,
                    input ready);
    modport sink (input valid, input out_byte, input out_byte_valid, input out_last,
                  output ready);
endinterface

@@ hdl/b64sd_front.sv @@
module b64sd_front (
    input  logic             clk,
    input  logic             rst_n,
    b64sd_char_if.sink       chars,
    input  logic             q_full,
    output logic             push,
    output b64sd_pkg::group_t push_group
);
    import b64sd_pkg::*;

    logic [2:0][5:0] buf_reg;
    logic [2:0][5:0] buf_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic            stopped_reg;
    logic            stopped_next;

    logic            accept;
    sextet_t         sx;
    logic            active;
    logic            take;
    logic            full_grp;
    logic [2:0][5:0] upd;
    logic [1:0]      cnt_upd;
    logic [2:0][5:0] src;

    assign chars.ready = !q_full;
    assign accept      = chars.valid && chars.ready;
    assign sx          = sextet_of(chars.in_char);
    assign active      = !stopped_reg;
    assign take        = active && !sx.stop;
    assign full_grp    = take && (cnt_reg == 2'd3);

    always_comb
    begin
        upd     = buf_reg;
        cnt_upd = cnt_reg;
        if (take && !full_grp)
        begin
            case (cnt_reg)
                2'd0:    upd[0] = sx.val;
                2'd1:    upd[1] = sx.val;
                default: upd[2] = sx.val;
            endcase
            cnt_upd = cnt_reg + 2'd1;
        end
        if (full_grp)
        begin
            cnt_upd = 2'd0;
        end
    end

    assign src = full_grp ? buf_reg : upd;

    always_comb
    begin
        push_group.data[0]  = byte_hi(src[0], src[1]);
        push_group.data[1]  = byte_mid(src[1], src[2]);
        push_group.data[2]  = byte_lo(src[2], sx.val);
        push_group.last     = chars.in_last;
        push_group.has_data = 1'b1;
        push_group.last_idx = WORD_IDX_THIRD;
        if (!full_grp)
        begin
            if (cnt_upd >= 2'd2)
            begin
                push_group.last_idx = cnt_upd - 2'd2;
            end else begin
                push_group.has_data = 1'b0;
                push_group.last_idx = WORD_IDX_FIRST;
            end
        end
    end

    assign push = accept && (full_grp || chars.in_last);

    always_comb
    begin
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        stopped_next = stopped_reg;
        if (accept)
        begin
            if (chars.in_last)
            begin
                buf_next     = '0;
                cnt_next     = 2'd0;
                stopped_next = 1'b0;
            end else begin
                buf_next     = full_grp ? '0 : upd;
                cnt_next     = cnt_upd;
                stopped_next = stopped_reg || (active && sx.stop);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg     <= '0;
            cnt_reg     <= 2'd0;
            stopped_reg <= 1'b0;
        end else begin
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

@@ hdl/b64sd_queue.sv @@
module b64sd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64sd_pkg::group_t push_group,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output b64sd_pkg::group_t head
);
    import b64sd_pkg::*;

    group_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full       = count_reg == QCNT_W'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("Group pushed into a full queue.");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("Group popped from an empty queue.");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("Queue occupancy out of range.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Queue pointers disagree with an empty count.");
`endif

endmodule

@@ hdl/b64sd_back.sv @@
module b64sd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  b64sd_pkg::group_t head,
    output logic              pop,
    b64sd_byte_if.source      bytes
);
    import b64sd_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       ov_reg;
    logic       ov_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       bv_reg;
    logic       bv_next;
    logic       last_reg;
    logic       last_next;

    logic       load;
    logic       final_word;
    logic [7:0] sel_byte;

    assign load       = head_valid && (!ov_reg || bytes.ready);
    assign final_word = idx_reg == head.last_idx;
    assign pop        = load && final_word;

    always_comb
    begin
        unique case (idx_reg)
            WORD_IDX_FIRST:  sel_byte = head.data[0];
            WORD_IDX_SECOND: sel_byte = head.data[1];
            default:         sel_byte = head.data[2];
        endcase
    end

    always_comb
    begin
        byte_next = byte_reg;
        bv_next   = bv_reg;
        last_next = last_reg;
        idx_next  = idx_reg;
        ov_next   = ov_reg && !bytes.ready;
        if (load)
        begin
            byte_next = head.has_data ? sel_byte : 8'd0;
            bv_next   = head.has_data;
            last_next = head.last && final_word;
            idx_next  = final_word ? WORD_IDX_FIRST : idx_reg + 2'd1;
            ov_next   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        bv_reg   <= bv_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= WORD_IDX_FIRST;
            ov_reg  <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    assign bytes.valid          = ov_reg;
    assign bytes.out_byte       = byte_reg;
    assign bytes.out_byte_valid = bv_reg;
    assign bytes.out_last       = last_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != WORD_IDX_FIRST) |-> head_valid)
        else $error("Word index advanced with no group at the queue head.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !head.has_data) |-> (head.last && head.last_idx == WORD_IDX_FIRST))
        else $error("End marker group is malformed.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !bv_reg) |-> last_reg)
        else $error("Bare end marker shown without last.");
`endif

endmodule

@@ hdl/base64_stream_decoder_unit.sv @@
// Takes one character word per cycle while the group queue has room.
// A character that completes a group, or the last character, yields one to three
// output words; the first goes into the group queue at the accepting edge, then into
// the output word register before it is offered. Output is one word per cycle while
// a group waits and ready is high; the four-entry group queue absorbs bursts.
// Reset (rst_n low, asynchronous) empties the queue and clears the sextet state.
module base64_stream_decoder_unit (
    input  logic         clk,
    input  logic         rst_n,
    b64sd_char_if.sink   chars,
    b64sd_byte_if.source bytes
);
    import b64sd_pkg::*;

    logic   push;
    group_t push_group;
    logic   q_full;
    logic   pop;
    logic   head_valid;
    group_t head;

    b64sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .q_full     (q_full),
        .push       (push),
        .push_group (push_group)
    );

    b64sd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    b64sd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .bytes      (bytes)
    );

endmodule

@@ dv/b64sd_decode_checker.sv @@
module b64sd_decode_checker (
    input  logic  clk,
    input  logic  rst_n,
    b64sd_char_if chars,
    b64sd_byte_if bytes,
    output int    pending,
    output int    mismatches,
    output int    words_checked,
    output int    end_markers
);
    timeunit 1ns;
    timeprecision 1ps;

    import b64sd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       last;
    } out_word_t;

    out_word_t  expected_words[$];
    logic [5:0] group_sextets[3];
    logic [1:0] sextet_cnt;
    logic       decode_stopped;
    int         pending_cnt;
    int         mismatch_cnt;
    int         checked_cnt;
    int         marker_cnt;

    assign pending       = pending_cnt;
    assign mismatches    = mismatch_cnt;
    assign words_checked = checked_cnt;
    assign end_markers   = marker_cnt;

    // Bit 6 set means the character stops decoding.
    function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            v = c - CHAR_UPPER_A;
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            v = c - CHAR_LOWER_A + 8'd26;
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            v = c - CHAR_DIGIT_0 + 8'd52;
        end else if (c == CHAR_PLUS) begin
            v = 8'd62;
        end else if (c == CHAR_SLASH) begin
            v = 8'd63;
        end else begin
            return {1'b1, 6'd0};
        end
        return {1'b0, v[5:0]};
    endfunction

    function automatic logic [7:0] join_sextets(input logic [1:0] idx, input logic [5:0] a,
                                                input logic [5:0] b);
        case (idx)
            WORD_IDX_FIRST:  return {a, b[5:4]};
            WORD_IDX_SECOND: return {a[3:0], b[5:2]};
            default:         return {a[1:0], b};
        endcase
    endfunction

    task automatic expect_word(input logic [7:0] d, input logic hd, input logic l);
        out_word_t w;
        w.data     = d;
        w.has_data = hd;
        w.last     = l;
        expected_words.push_back(w);
    endtask

    task automatic clear_group();
        group_sextets[0] = 6'd0;
        group_sextets[1] = 6'd0;
        group_sextets[2] = 6'd0;
        sextet_cnt       = 2'd0;
    endtask

    task automatic predict_char(input logic [7:0] c, input logic lst);
        logic [6:0] lookup;
        int         produced;
        int         held;
        produced = 0;
        if (!decode_stopped) begin
            lookup = sextet_lookup(c);
            if (lookup[6]) begin
                decode_stopped = 1'b1;
            end else if (sextet_cnt == 2'd3) begin
                expect_word(join_sextets(WORD_IDX_FIRST, group_sextets[0], group_sextets[1]),
                            1'b1, 1'b0);
                expect_word(join_sextets(WORD_IDX_SECOND, group_sextets[1], group_sextets[2]),
                            1'b1, 1'b0);
                expect_word(join_sextets(WORD_IDX_THIRD, group_sextets[2], lookup[5:0]),
                            1'b1, lst);
                produced = 3;
                clear_group();
            end else begin
                group_sextets[sextet_cnt] = lookup[5:0];
                sextet_cnt                = sextet_cnt + 2'd1;
            end
        end
        if (lst) begin
            held = int'(sextet_cnt);
            if (produced == 0) begin
                if (held >= 2) begin
                    for (int k = 0; k < held - 1; k++) begin
                        expect_word(join_sextets(k[1:0], group_sextets[k], group_sextets[k + 1]),
                                    1'b1, k == held - 2);
                    end
                end else begin
                    expect_word(8'd0, 1'b0, 1'b1);
                end
            end
            clear_group();
            decode_stopped = 1'b0;
        end
    endtask

    task automatic check_word(input logic [7:0] d, input logic hd, input logic l);
        out_word_t w;
        checked_cnt++;
        if (!hd) marker_cnt++;
        if (expected_words.size() == 0) begin
            $error("unexpected output word: out_byte=%0h out_byte_valid=%0b out_last=%0b",
                   d, hd, l);
            mismatch_cnt++;
            return;
        end
        w = expected_words.pop_front();
        if (d !== w.data) begin
            $error("out_byte: expected %0h, got %0h", w.data, d);
            mismatch_cnt++;
        end
        if (hd !== w.has_data) begin
            $error("out_byte_valid: expected %0b, got %0b", w.has_data, hd);
            mismatch_cnt++;
        end
        if (l !== w.last) begin
            $error("out_last: expected %0b, got %0b", w.last, l);
            mismatch_cnt++;
        end
    endtask

    initial begin
        mismatch_cnt = 0;
        checked_cnt  = 0;
        marker_cnt   = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            expected_words.delete();
            clear_group();
            decode_stopped = 1'b0;
            pending_cnt <= 0;
        end else begin
            if (bytes.valid && bytes.ready) begin
                check_word(bytes.out_byte, bytes.out_byte_valid, bytes.out_last);
            end
            if (chars.valid && chars.ready) begin
                predict_char(chars.in_char, chars.in_last);
            end
            pending_cnt <= expected_words.size();
        end
    end

endmodule

@@ dv/tb_base64_stream_decoder_unit.sv @@
module tb_base64_stream_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import b64sd_pkg::*;

    typedef logic [7:0] char_q_t[$];

    localparam string      ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [7:0] CHAR_PAD       = 8'h3D;
    localparam int         TARGET_CHARS   = 310;
    localparam int         HOLD_OFF_LEN   = 120;
    localparam int         DRAIN_CYCLES   = 10;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;

    int   pending_words;
    int   mismatches;
    int   words_checked;
    int   end_markers;

    int   live_chars   = 0;
    int   texts_sent   = 0;
    int   idle_cycles  = 0;
    bit   src_idle_en  = 1'b1;
    bit   sink_idle_en = 1'b1;
    bit   hold_off_req = 1'b0;

    b64sd_char_if chars_if ();
    b64sd_byte_if bytes_if ();

    base64_stream_decoder_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .bytes (bytes_if)
    );

    b64sd_decode_checker u_decode_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .chars         (chars_if),
        .bytes         (bytes_if),
        .pending       (pending_words),
        .mismatches    (mismatches),
        .words_checked (words_checked),
        .end_markers   (end_markers)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit is_alphabet(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
               (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) ||
               c == CHAR_PLUS || c == CHAR_SLASH;
    endfunction

    function automatic logic [7:0] random_alpha();
        return ALPHABET[$urandom_range(0, 63)];
    endfunction

    function automatic logic [7:0] random_stop();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_alphabet(c)) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic char_q_t str_to_q(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    task automatic send_word(input logic [7:0] c, input logic lst);
        while (src_idle_en && $urandom_range(0, 99) < 37) begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.in_char <= c;
        chars_if.in_last <= lst;
        @(posedge clk);
        while (!chars_if.ready) @(posedge clk);
    endtask

    // Characters after a stop are ignored by the block and, but for the last one, are not counted.
    task automatic send_text(input char_q_t txt);
        logic halted;
        halted = 1'b0;
        foreach (txt[i]) begin
            if (!halted || i == txt.size() - 1) live_chars++;
            if (!is_alphabet(txt[i])) halted = 1'b1;
            send_word(txt[i], i == txt.size() - 1);
        end
        texts_sent++;
    endtask

    task automatic wait_drained();
        chars_if.valid <= 1'b0;
        do @(posedge clk); while (pending_words != 0);
    endtask

    initial begin
        bytes_if.ready = 1'b0;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                bytes_if.ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            bytes_if.ready <= !sink_idle_en || $urandom_range(0, 99) >= 37;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if ((chars_if.valid && chars_if.ready) || (bytes_if.valid && bytes_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        char_q_t txt;
        int      kind;
        int      n;
        bit      hold_off_done;
        bit      quiet_done;
        hold_off_done    = 1'b0;
        quiet_done       = 1'b0;
        rst_n            = 1'b0;
        chars_if.valid   = 1'b0;
        chars_if.in_char = 8'd0;
        chars_if.in_last = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_text(str_to_q("TWFu"));
        send_text(str_to_q("TWE="));
        send_text(str_to_q("TQ=="));
        send_text(str_to_q("A"));
        txt = '{8'hFF, CHAR_UPPER_Z};
        send_text(txt);
        txt = str_to_q("az09+/");
        txt.push_back(8'h00);
        send_text(txt);
        send_text(str_to_q("/"));
        wait_drained();

        while (live_chars < TARGET_CHARS) begin
            if (!hold_off_done && live_chars >= 100) begin
                // Let the block drain, then starve the output while feeding at full rate.
                wait_drained();
                hold_off_done = 1'b1;
                src_idle_en   = 1'b0;
                sink_idle_en  = 1'b0;
                hold_off_req  = 1'b1;
            end
            if (!quiet_done && live_chars >= 200) begin
                quiet_done   = 1'b1;
                src_idle_en  = 1'b1;
                sink_idle_en = 1'b1;
            end
            txt.delete();
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                n = $urandom_range(1, 12);
                repeat (n) txt.push_back(random_alpha());
                if ($urandom_range(0, 1) == 1) begin
                    repeat ((n % 4 == 2) ? 2 : (n % 4 == 3) ? 1 : 0) txt.push_back(CHAR_PAD);
                end
            end else if (kind <= 8) begin
                repeat ($urandom_range(0, 6)) txt.push_back(random_alpha());
                txt.push_back(random_stop());
                repeat ($urandom_range(0, 4)) txt.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
            end
            send_text(txt);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d texts with %0d decoded characters, random stalls and a %0d-cycle",
                 texts_sent, live_chars, HOLD_OFF_LEN);
        $display("output hold-off; %0d output words checked, %0d of them end markers.",
                 words_checked, end_markers);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
